>>> rtl/touch_long_press_detector_unit_defines.svh
// assertion macros shared by the long-press detector modules
`ifndef TOUCH_LONG_PRESS_DETECTOR_UNIT_DEFINES_SVH
`define TOUCH_LONG_PRESS_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every clk edge outside reset
`define TLPD_ASSERT_IMPLIES(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tlpd implication check failed");
// next-cycle implication
`define TLPD_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tlpd next-cycle check failed");
`else
`define TLPD_ASSERT_IMPLIES(label, a, b)
`define TLPD_ASSERT_NEXT(label, a, b)
`endif

`endif

>>> rtl/tlpd_pkg.sv
// shared types and constants for the long-press detector
`timescale 1ns / 1ps
package tlpd_pkg;

  // request codes
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_BEGIN  = 3'd1;
  localparam logic [2:0] REQ_MOVE   = 3'd2;
  localparam logic [2:0] REQ_END    = 3'd3;
  localparam logic [2:0] REQ_CANCEL = 3'd4;

  // action codes
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_MENU   = 2'd1;
  localparam logic [1:0] ACT_EDITOR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEAD_ZONE  = 2'd0;
  localparam logic [1:0] CFG_FILL       = 2'd1;
  localparam logic [1:0] CFG_MOVE_LIMIT = 2'd2;

  localparam logic [15:0] DEAD_ZONE_RST  = 16'd500;
  localparam logic [15:0] FILL_RST       = 16'd1000;
  localparam logic [11:0] MOVE_LIMIT_RST = 12'd240;

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
  localparam logic [8:0]  PROG_FULL   = 9'd256;
  localparam logic [3:0]  FINGER_CAP  = 4'd2;
  localparam logic [2:0]  DIV_LAST    = 3'd7;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  touch_count;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [9:0]  tick_ms;
    logic        overlay_open;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic       bar_visible;
    logic [8:0] progress;
    logic       hold_active;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic update;
    logic mul_x;
    logic mul_y;
    logic mul_l;
    logic mul_cmp;
    logic prep;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic move_check;
  } status_t;

endpackage

>>> rtl/tlpd_ctrl.sv
// sequencing controller for the long-press detector
`timescale 1ns / 1ps
`include "touch_long_press_detector_unit_defines.svh"
module tlpd_ctrl
  import tlpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_L,
    S_MUL_CMP,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] div_cnt_r, div_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = status.move_check ? S_MUL_X : S_PREP;
      end
      S_MUL_X: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_MUL_L;
      end
      S_MUL_L: begin
        cmd.mul_l = 1'b1;
        state_nxt = S_MUL_CMP;
      end
      S_MUL_CMP: begin
        cmd.mul_cmp = 1'b1;
        state_nxt   = S_PREP;
      end
      S_PREP: begin
        cmd.prep    = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 3'd1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TLPD_ASSERT_NEXT(a_one_item_in_flight, in_valid && in_ready, !in_ready)
  `TLPD_ASSERT_IMPLIES(a_no_result_overwrite, cmd.load_out, !out_valid_r || out_ready)
  `TLPD_ASSERT_NEXT(a_mul_sequence, state_r == S_MUL_X, state_r == S_MUL_Y)

endmodule

>>> rtl/tlpd_dpath.sv
// hold state, distance check and progress divider for the long-press detector
`timescale 1ns / 1ps
`include "touch_long_press_detector_unit_defines.svh"
module tlpd_dpath
  import tlpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output status_t   status,
  output out_item_t out_item
);

  localparam logic [1:0] PSEL_ZERO = 2'd0;
  localparam logic [1:0] PSEL_FULL = 2'd1;
  localparam logic [1:0] PSEL_DIV  = 2'd2;

  // configuration
  logic [15:0] dead_r;
  logic [15:0] fill_r;
  logic [11:0] lim_r;

  // hold state
  logic        active_r;
  logic        completed_r;
  logic        bar_r;
  logic [3:0]  fingers_r;
  logic [16:0] elapsed_r;
  logic [15:0] start_x_r;
  logic [15:0] start_y_r;

  // per-item work registers
  in_item_t    item_r;
  logic [1:0]  action_r;
  logic [31:0] prod_r;
  logic [32:0] acc_r;
  logic [15:0] rem_r;
  logic [7:0]  quo_r;
  logic [1:0]  psel_r;
  out_item_t   out_r;

  logic [17:0] el_sum;
  logic [16:0] el_sat;
  logic [16:0] el_done;
  logic [4:0]  fg_sum;
  logic [15:0] adx;
  logic [15:0] ady;
  logic [15:0] mul_a;
  logic [31:0] mul_p;
  logic [16:0] diff;
  logic [16:0] rem_dbl;
  logic        hold_clr;

  assign el_sum  = {1'b0, elapsed_r} + {8'd0, item_r.tick_ms};
  assign el_sat  = (el_sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : el_sum[16:0];
  assign el_done = {1'b0, dead_r} + {1'b0, fill_r};
  assign fg_sum  = {1'b0, fingers_r} + {1'b0, item_r.touch_count};

  // distance from the start point, one shared multiplier
  assign adx   = (item_r.pos_x >= start_x_r) ? item_r.pos_x - start_x_r
                                             : start_x_r - item_r.pos_x;
  assign ady   = (item_r.pos_y >= start_y_r) ? item_r.pos_y - start_y_r
                                             : start_y_r - item_r.pos_y;
  assign mul_a = cmd.mul_x ? adx : (cmd.mul_y ? ady : {4'd0, lim_r});
  assign mul_p = {16'd0, mul_a} * {16'd0, mul_a};

  assign diff    = elapsed_r - {1'b0, dead_r};
  assign rem_dbl = {rem_r, 1'b0};

  assign status.move_check = (item_r.req_type == REQ_MOVE) && active_r && !completed_r
                             && (item_r.touch_count != 4'd0);

  // hold reset requested by the current item
  always_comb begin
    hold_clr = 1'b0;
    if (cmd.update) begin
      case (item_r.req_type)
        REQ_END:    hold_clr = active_r && (item_r.touch_count >= fingers_r);
        REQ_CANCEL: hold_clr = 1'b1;
        default:    hold_clr = 1'b0;
      endcase
    end
    if (cmd.mul_cmp && (acc_r > {1'b0, prod_r})) begin
      hold_clr = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_r      <= DEAD_ZONE_RST;
      fill_r      <= FILL_RST;
      lim_r       <= MOVE_LIMIT_RST;
      active_r    <= 1'b0;
      completed_r <= 1'b0;
      bar_r       <= 1'b0;
      fingers_r   <= '0;
      elapsed_r   <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      out_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEAD_ZONE:  dead_r <= cfg_data;
          CFG_FILL:       fill_r <= cfg_data;
          CFG_MOVE_LIMIT: lim_r  <= cfg_data[11:0];
          default:        ;
        endcase
      end

      if (hold_clr) begin
        active_r    <= 1'b0;
        completed_r <= 1'b0;
        bar_r       <= 1'b0;
        fingers_r   <= '0;
        elapsed_r   <= '0;
      end else if (cmd.update) begin
        case (item_r.req_type)
          REQ_TICK: begin
            if (active_r && !completed_r) begin
              elapsed_r <= el_sat;
              if (el_sat >= {1'b0, dead_r}) begin
                if (el_sat >= el_done) begin
                  bar_r       <= 1'b0;
                  completed_r <= 1'b1;
                end else begin
                  bar_r <= 1'b1;
                end
              end
            end
          end
          REQ_BEGIN: begin
            if (!item_r.overlay_open) begin
              if (!active_r) begin
                active_r    <= 1'b1;
                fingers_r   <= item_r.touch_count;
                elapsed_r   <= '0;
                completed_r <= 1'b0;
                bar_r       <= 1'b0;
                if (item_r.touch_count != 4'd0) begin
                  start_x_r <= item_r.pos_x;
                  start_y_r <= item_r.pos_y;
                end
              end else if (!completed_r) begin
                fingers_r <= (fg_sum > {1'b0, FINGER_CAP}) ? FINGER_CAP : fg_sum[3:0];
              end
            end
          end
          REQ_END: begin
            if (active_r) begin
              fingers_r <= fingers_r - item_r.touch_count;
            end
          end
          default: ;
        endcase
      end

      if (cmd.load_out) begin
        out_r.action      <= action_r;
        out_r.bar_visible <= bar_r;
        out_r.hold_active <= active_r;
        case (psel_r)
          PSEL_FULL: out_r.progress <= PROG_FULL;
          PSEL_DIV:  out_r.progress <= {1'b0, quo_r};
          default:   out_r.progress <= '0;
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    if (cmd.update) begin
      if ((item_r.req_type == REQ_TICK) && active_r && !completed_r
          && (el_sat >= {1'b0, dead_r}) && (el_sat >= el_done)) begin
        action_r <= (fingers_r >= FINGER_CAP) ? ACT_EDITOR : ACT_MENU;
      end else begin
        action_r <= ACT_NONE;
      end
    end
    if (cmd.mul_x) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_y) begin
      acc_r  <= {1'b0, prod_r};
      prod_r <= mul_p;
    end
    if (cmd.mul_l) begin
      acc_r  <= acc_r + {1'b0, prod_r};
      prod_r <= mul_p;
    end
    if (cmd.prep) begin
      quo_r <= '0;
      rem_r <= diff[15:0];
      if (!active_r || (elapsed_r < {1'b0, dead_r})) begin
        psel_r <= PSEL_ZERO;
      end else if (diff >= {1'b0, fill_r}) begin
        psel_r <= PSEL_FULL;
      end else begin
        psel_r <= PSEL_DIV;
      end
    end
    // restoring division of diff*256 by fill, one quotient bit per step
    if (cmd.div_step) begin
      if (rem_dbl >= {1'b0, fill_r}) begin
        rem_r <= 16'(rem_dbl - {1'b0, fill_r});
        quo_r <= {quo_r[6:0], 1'b1};
      end else begin
        rem_r <= rem_dbl[15:0];
        quo_r <= {quo_r[6:0], 1'b0};
      end
    end
  end

  assign out_item = out_r;

  `TLPD_ASSERT_IMPLIES(a_progress_range, 1'b1, out_r.progress <= PROG_FULL)
  `TLPD_ASSERT_IMPLIES(a_fire_hides_bar, out_r.action != ACT_NONE, !out_r.bar_visible)
  `TLPD_ASSERT_IMPLIES(a_fire_stays_active, out_r.action != ACT_NONE, out_r.hold_active)

endmodule

>>> rtl/touch_long_press_detector_unit.sv
// top level of the touch long-press detector: controller plus datapath
// each accepted item runs through update, the distance check for a checked move (the shared 16x16
// squaring multiplier, used for x, y and the limit in turn), progress setup and the 8-step
// progress divider; the next item is accepted only after this result is loaded for output
// reset (rst_n low, synchronous): hold idle, start point zero, registers to 500/1000/240
`timescale 1ns / 1ps
module touch_long_press_detector_unit
  import tlpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  // result item channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  // configuration writes, index 0 dead zone, 1 fill time, 2 move limit
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // the controller walks each item through update, optional distance check,
  // progress setup and division; the datapath holds all gesture state
  cmd_t    cmd;
  status_t status;

  tlpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // result register lives in the datapath, so a waiting result does not
  // block acceptance of the next item
  tlpd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

endmodule
